// File: hdl/fccm_pkg.sv
// ----------------------------------------------------------------------------
// fccm_pkg
// Shared types and constants of the cluster chain manager: request and
// response payloads, command and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
package fccm_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int CMD_W             = 3;
  localparam int CLU_W             = 10;
  localparam int ST_W              = 2;
  localparam int LINK_W            = 32;
  localparam int RSV_ENTRIES       = 3;

  localparam logic [LINK_W-1:0] END_OF_CHAIN = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC      = 3'd0,
    CMD_FREE_CHAIN = 3'd1,
    CMD_FREE_ONE   = 3'd2,
    CMD_FIND_TAIL  = 3'd3,
    CMD_APPEND     = 3'd4
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_BROKEN = 2'd3
  } status_e;

  // which register feeds the result cluster
  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_QADDR = 2'd1,
    SRC_FRESH = 2'd2
  } res_src_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [CLU_W-1:0] start_cluster;
  } fccm_req_t;

  typedef struct packed {
    logic [CLU_W-1:0] cluster;
    logic [ST_W-1:0]  status;
  } fccm_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic     clr_step;
    logic     load;
    logic     start_walk;
    logic     start_scan;
    logic     walk_next;
    logic     scan_next;
    logic     walk_clear;
    logic     free_one;
    logic     take_free;
    logic     set_tail;
    logic     link;
    logic     mark_full;
    logic     res_we;
    status_e  res_status;
    res_src_e res_src;
    logic     out_load;
  } dp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic             clr_last;
    logic             in_range;
    logic             hint_full;
    logic             q_zero;
    logic             q_eoc;
    logic             q_big;
    logic             walk_last;
    logic             scan_last;
    logic [CMD_W-1:0] cmd;
  } dp_stat_t;

endpackage

// File: hdl/fccm_dpath.sv
// ----------------------------------------------------------------------------
// fccm_dpath
// Link table memory with a write-first registered read port, walk and
// free-search address registers, lowest-free hint and result registers.
// ----------------------------------------------------------------------------
module fccm_dpath #(
  parameter int TABLE_ENTRIES = fccm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  fccm_pkg::fccm_req_t req,
  input  fccm_pkg::dp_ctl_t   ctl,
  output fccm_pkg::dp_stat_t  stat,
  output fccm_pkg::fccm_rsp_t rsp
);
  import fccm_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int HW = AW + 1;
  localparam logic [AW-1:0] LAST      = AW'(TABLE_ENTRIES - 1);
  localparam logic [HW-1:0] HINT_FULL = HW'(TABLE_ENTRIES);
  localparam logic [HW-1:0] HINT_RST  = HW'(RSV_ENTRIES);

  logic [LINK_W-1:0] mem [TABLE_ENTRIES];
  logic [LINK_W-1:0] q;
  logic [AW-1:0]     q_addr;
  logic [AW-1:0]     steps;
  logic [AW-1:0]     tail;
  logic [AW-1:0]     fresh;
  logic [AW-1:0]     clr_cnt;
  logic [AW-1:0]     res_cluster;
  logic [ST_W-1:0]   res_status;
  logic [HW-1:0]     hint;
  logic [CMD_W-1:0]  cmd_q;

  logic [AW-1:0]     start_a;
  logic [AW-1:0]     ra;
  logic [AW-1:0]     wa;
  logic [LINK_W-1:0] wd;
  logic              we;
  logic [AW-1:0]     zero_addr;
  logic              zero_en;
  logic [AW-1:0]     res_next;

  assign start_a = AW'(req.start_cluster);

  // read address
  always_comb begin
    if (ctl.start_walk) begin
      ra = start_a;
    end else if (ctl.start_scan) begin
      ra = hint[AW-1:0];
    end else if (ctl.walk_next) begin
      ra = q[AW-1:0];
    end else begin
      ra = q_addr + AW'(1);
    end
  end

  // write port, at most one source per cycle
  always_comb begin
    we = 1'b1;
    wa = q_addr;
    wd = '0;
    if (ctl.clr_step) begin
      wa = clr_cnt;
      wd = (clr_cnt < AW'(RSV_ENTRIES)) ? END_OF_CHAIN : '0;
    end else if (ctl.walk_clear) begin
      wa = q_addr;
    end else if (ctl.free_one) begin
      wa = start_a;
    end else if (ctl.take_free) begin
      wa = q_addr;
      wd = END_OF_CHAIN;
    end else if (ctl.link) begin
      wa = tail;
      wd = LINK_W'(fresh);
    end else begin
      we = 1'b0;
    end
  end

  // write-first, so a self link read in the same cycle as its clear sees zero
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (we && (wa == ra)) begin
      q <= wd;
    end else begin
      q <= mem[ra];
    end
  end

  assign zero_addr = ctl.free_one ? start_a : q_addr;
  assign zero_en   = ctl.walk_clear | ctl.free_one;

  // every entry below hint is in use
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      hint    <= HINT_RST;
    end else begin
      if (ctl.clr_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (ctl.mark_full) begin
        hint <= HINT_FULL;
      end else if (ctl.take_free) begin
        hint <= {1'b0, q_addr} + HW'(1);
      end else if (zero_en && ({1'b0, zero_addr} < hint)) begin
        hint <= {1'b0, zero_addr};
      end
    end
  end

  always_comb begin
    case (ctl.res_src)
      SRC_QADDR: res_next = q_addr;
      SRC_FRESH: res_next = fresh;
      default:   res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= req.command;
    end
    if (ctl.start_walk || ctl.start_scan || ctl.walk_next || ctl.scan_next) begin
      q_addr <= ra;
    end
    if (ctl.start_walk) begin
      steps <= '0;
    end else if (ctl.walk_next) begin
      steps <= steps + AW'(1);
    end
    if (ctl.take_free) begin
      fresh <= q_addr;
    end
    if (ctl.set_tail) begin
      tail <= q_addr;
    end
    if (ctl.res_we) begin
      res_status  <= ctl.res_status;
      res_cluster <= res_next;
    end
    if (ctl.out_load) begin
      rsp.cluster <= CLU_W'(res_cluster);
      rsp.status  <= res_status;
    end
  end

  assign stat.clr_last  = (clr_cnt == LAST);
  assign stat.in_range  = (32'(req.start_cluster) < 32'(TABLE_ENTRIES));
  assign stat.hint_full = (hint == HINT_FULL);
  assign stat.q_zero    = (q == '0);
  assign stat.q_eoc     = (q == END_OF_CHAIN);
  assign stat.q_big     = (q >= LINK_W'(TABLE_ENTRIES));
  assign stat.walk_last = (steps == LAST);
  assign stat.scan_last = (q_addr == LAST);
  assign stat.cmd       = cmd_q;

endmodule

// File: hdl/fccm_ctrl.sv
// ----------------------------------------------------------------------------
// fccm_ctrl
// Sequencer: table clear after reset, request decode, chain walk,
// free-entry search, append link and response handoff.
// ----------------------------------------------------------------------------
module fccm_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [fccm_pkg::CMD_W-1:0] req_cmd,
  input  logic                       rsp_ready,
  input  fccm_pkg::dp_stat_t         stat,
  output logic                       req_ready,
  output logic                       rsp_valid,
  output fccm_pkg::dp_ctl_t          ctl
);
  import fccm_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_WALK  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_LINK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          ctl.load   = 1'b1;
          ctl.res_we = 1'b1;
          state_next = S_DONE;
          case (req_cmd)
            CMD_ALLOC: begin
              if (stat.hint_full) begin
                ctl.res_status = ST_FULL;
              end else begin
                ctl.res_we     = 1'b0;
                ctl.start_scan = 1'b1;
                state_next     = S_SCAN;
              end
            end
            CMD_FREE_CHAIN, CMD_FIND_TAIL, CMD_APPEND: begin
              if (!stat.in_range) begin
                ctl.res_status = ST_RANGE;
              end else begin
                ctl.res_we     = 1'b0;
                ctl.start_walk = 1'b1;
                state_next     = S_WALK;
              end
            end
            CMD_FREE_ONE: begin
              if (!stat.in_range) begin
                ctl.res_status = ST_RANGE;
              end else begin
                ctl.free_one = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (stat.q_zero) begin
          ctl.res_we     = 1'b1;
          ctl.res_status = ST_BROKEN;
          state_next     = S_DONE;
        end else begin
          ctl.walk_clear = (stat.cmd == CMD_FREE_CHAIN);
          if (stat.q_eoc) begin
            ctl.set_tail = 1'b1;
            ctl.res_we   = 1'b1;
            state_next   = S_DONE;
            if (stat.cmd == CMD_FIND_TAIL) begin
              ctl.res_src = SRC_QADDR;
            end else if (stat.cmd == CMD_APPEND) begin
              if (stat.hint_full) begin
                ctl.res_status = ST_FULL;
              end else begin
                ctl.res_we     = 1'b0;
                ctl.start_scan = 1'b1;
                state_next     = S_SCAN;
              end
            end
          end else if (stat.q_big) begin
            ctl.res_we     = 1'b1;
            ctl.res_status = ST_RANGE;
            state_next     = S_DONE;
          end else if (stat.walk_last) begin
            // visited as many entries as the table holds
            ctl.res_we     = 1'b1;
            ctl.res_status = ST_BROKEN;
            state_next     = S_DONE;
          end else begin
            ctl.walk_next = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (stat.q_zero) begin
          ctl.take_free = 1'b1;
          if (stat.cmd == CMD_APPEND) begin
            state_next = S_LINK;
          end else begin
            ctl.res_we  = 1'b1;
            ctl.res_src = SRC_QADDR;
            state_next  = S_DONE;
          end
        end else if (stat.scan_last) begin
          ctl.mark_full  = 1'b1;
          ctl.res_we     = 1'b1;
          ctl.res_status = ST_FULL;
          state_next     = S_DONE;
        end else begin
          ctl.scan_next = 1'b1;
        end
      end
      S_LINK: begin
        ctl.link    = 1'b1;
        ctl.res_we  = 1'b1;
        ctl.res_src = SRC_FRESH;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= ctl.out_load | (rsp_valid & ~rsp_ready);
    end
  end

endmodule

// File: hdl/fat_cluster_chain_manager.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_manager
// Cluster link table with allocate, free chain, free one, find tail and
// append commands; one response per request.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  request   req_valid / req_ready   req.command, req.start_cluster
//  response  rsp_valid / rsp_ready   rsp.cluster, rsp.status
//
//  after reset the table is cleared one entry per cycle, with req_ready low
//  until every entry is written. one request is in work at a time.
//  free one, out-of-range and unused commands are answered from decode; a
//  walk visits one chain entry per step; allocate searches upward from the
//  lowest-free hint; append takes its walk, its search and a link step.
//  the table has a single read and a single write port, which paces walks.
//  a stalled response sits in the output register; the next request is
//  still taken and waits for it only at the end of its own work.
// ----------------------------------------------------------------------------
module fat_cluster_chain_manager #(
  parameter int TABLE_ENTRIES = fccm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  fccm_pkg::fccm_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output fccm_pkg::fccm_rsp_t rsp
);
  import fccm_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  fccm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.command),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .ctl       (ctl)
  );

  fccm_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .ctl  (ctl),
    .stat (stat),
    .rsp  (rsp)
  );

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

  // any error or full answer carries no cluster
  a_err_no_cluster: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.cluster == '0))
    else $error("error response with nonzero cluster");

  // a new response only rises out of work, never straight from idle
  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("response raised without work");

  // chain clears come only from work, never with a free-entry take or a link
  a_clear_only_walk: assert property (@(posedge clk) disable iff (rst)
    ctl.walk_clear |-> !req_ready && !ctl.take_free && !ctl.link)
    else $error("chain clear outside a walk");

endmodule

// File: tb/sv/tb_fat_cluster_chain_manager.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fat_cluster_chain_manager
// Drives allocate, free and chain-walk requests into the cluster chain manager
// with random gaps and response stalls. A shadow link table predicts each
// response. Checks compare every response in order. The run ends with a
// gap-free burst of mostly appends, frees recent chains, allocates and appends.
// ----------------------------------------------------------------------------
module tb_fat_cluster_chain_manager;
  import fccm_pkg::*;

  localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 340;
  localparam int TAIL_ITEMS   = 60;
  localparam int FREE_HEADS   = 20;
  localparam int QUEUE_AHEAD  = 4;
  localparam int CYCLE_LIMIT  = 4000000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  fccm_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  fccm_rsp_t rsp;

  fccm_req_t         pending_reqs[$];
  fccm_rsp_t         expected_rsps[$];
  fccm_rsp_t         rsp_want;
  logic [LINK_W-1:0] shadow_links[TABLE_ENTRIES];
  logic [CLU_W-1:0]  chain_heads[$];
  logic [CLU_W-1:0]  recent_clusters[$];
  int                req_gap = 0;
  int                rsp_stall = 0;
  int                cycle_count = 0;
  bit                idling_on = 1'b1;
  bit                failed = 1'b0;

  fat_cluster_chain_manager u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit lowest_free(output logic [CLU_W-1:0] idx);
    idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (shadow_links[i] == '0) begin
        idx = i[CLU_W-1:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // follows links from first; clear zeroes each entry as it is passed
  function automatic status_e follow_chain(input logic [CLU_W-1:0] first, input bit clear,
                                           output logic [CLU_W-1:0] tail);
    logic [CLU_W-1:0]  cur;
    logic [LINK_W-1:0] nxt;
    cur  = first;
    tail = '0;
    for (int n = 0; n < TABLE_ENTRIES; n++) begin
      nxt = shadow_links[cur];
      if (nxt == '0) return ST_BROKEN;
      if (clear) shadow_links[cur] = '0;
      if (nxt == END_OF_CHAIN) begin
        tail = cur;
        return ST_OK;
      end
      if (nxt >= TABLE_ENTRIES) return ST_RANGE;
      cur = nxt[CLU_W-1:0];
    end
    return ST_BROKEN;
  endfunction

  function automatic void forget_head(logic [CLU_W-1:0] c);
    for (int i = chain_heads.size() - 1; i >= 0; i--) begin
      if (chain_heads[i] == c) chain_heads.delete(i);
    end
  endfunction

  function automatic void note_cluster(logic [CLU_W-1:0] c);
    recent_clusters.push_back(c);
    if (recent_clusters.size() > 64) void'(recent_clusters.pop_front());
  endfunction

  function automatic fccm_rsp_t table_command(fccm_req_t r);
    fccm_rsp_t        res;
    logic [CLU_W-1:0] tail;
    logic [CLU_W-1:0] fresh;
    bit               in_range;
    res      = '0;
    in_range = (r.start_cluster < TABLE_ENTRIES);
    case (r.command)
      CMD_ALLOC: begin
        if (lowest_free(fresh)) begin
          shadow_links[fresh] = END_OF_CHAIN;
          res.cluster = fresh;
          chain_heads.push_back(fresh);
          if (chain_heads.size() > 256) void'(chain_heads.pop_front());
          note_cluster(fresh);
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_FREE_CHAIN: begin
        if (!in_range) res.status = ST_RANGE;
        else res.status = follow_chain(r.start_cluster, 1'b1, tail);
        forget_head(r.start_cluster);
      end
      CMD_FREE_ONE: begin
        if (!in_range) res.status = ST_RANGE;
        else shadow_links[r.start_cluster] = '0;
        forget_head(r.start_cluster);
      end
      CMD_FIND_TAIL: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else begin
          res.status = follow_chain(r.start_cluster, 1'b0, tail);
          if (res.status == ST_OK) res.cluster = tail;
        end
      end
      CMD_APPEND: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else begin
          res.status = follow_chain(r.start_cluster, 1'b0, tail);
          if (res.status == ST_OK) begin
            if (lowest_free(fresh)) begin
              shadow_links[tail]  = {{(LINK_W-CLU_W){1'b0}}, fresh};
              shadow_links[fresh] = END_OF_CHAIN;
              res.cluster = fresh;
              note_cluster(fresh);
            end else begin
              res.status = ST_FULL;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [CLU_W-1:0] any_cluster();
    return CLU_W'($urandom_range(0, TABLE_ENTRIES - 1));
  endfunction

  // head from the last span entries of the list, any cluster if there is none
  function automatic logic [CLU_W-1:0] pick_head(int span);
    int n;
    n = chain_heads.size();
    if (n == 0) return any_cluster();
    if (span > n) span = n;
    return chain_heads[n - 1 - $urandom_range(0, span - 1)];
  endfunction

  function automatic fccm_req_t random_request();
    fccm_req_t   r;
    int unsigned pick;
    r.command       = CMD_ALLOC;
    r.start_cluster = any_cluster();
    pick            = $urandom_range(0, 99);
    if (pick < 25) begin
      r.command = CMD_ALLOC;
    end else if (pick < 50) begin
      r.command = CMD_APPEND;
      if ($urandom_range(0, 4) != 0) r.start_cluster = pick_head(256);
    end else if (pick < 65) begin
      r.command = CMD_FIND_TAIL;
      if ($urandom_range(0, 4) != 0) r.start_cluster = pick_head(256);
    end else if (pick < 77) begin
      r.command = CMD_FREE_CHAIN;
      if ($urandom_range(0, 3) != 0) r.start_cluster = pick_head(256);
    end else if (pick < 87) begin
      // mid-chain frees leave broken chains behind
      r.command = CMD_FREE_ONE;
      if (recent_clusters.size() > 0 && $urandom_range(0, 1) == 0)
        r.start_cluster = recent_clusters[$urandom_range(0, recent_clusters.size() - 1)];
      else if ($urandom_range(0, 1) == 0)
        r.start_cluster = pick_head(256);
    end else if (pick < 92) begin
      r.command = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end else begin
      r.command = CMD_W'($urandom_range(CMD_ALLOC, CMD_APPEND));
    end
    return r;
  endfunction

  // mostly appends to recent chains so they grow long
  function automatic fccm_req_t fill_request();
    fccm_req_t r;
    r.command       = CMD_APPEND;
    r.start_cluster = pick_head(16);
    if (chain_heads.size() == 0 || $urandom_range(0, 7) == 0) r.command = CMD_ALLOC;
    return r;
  endfunction

  task automatic push_req(logic [CMD_W-1:0] cmd, logic [CLU_W-1:0] start);
    fccm_req_t r;
    r.command       = cmd;
    r.start_cluster = start;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_room();
    while (pending_reqs.size() >= QUEUE_AHEAD) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
      req_gap   <= 0;
    end else begin
      if (req_valid && req_ready) expected_rsps.push_back(table_command(req));
      if (!req_valid || req_ready) begin
        if (req_gap > 0) begin
          req_valid <= 1'b0;
          req_gap   <= req_gap - 1;
        end else if (pending_reqs.size() > 0) begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          if (idling_on && $urandom_range(0, 9) == 0) req_gap <= $urandom_range(1, 8);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_stall <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: response with none expected: cluster %0d status %0d",
                   $time, rsp.cluster, rsp.status);
          failed = 1'b1;
        end else begin
          rsp_want = expected_rsps.pop_front();
          if (rsp.cluster !== rsp_want.cluster) begin
            $display("%0t: cluster mismatch: expected %0d actual %0d",
                     $time, rsp_want.cluster, rsp.cluster);
            failed = 1'b1;
          end
          if (rsp.status !== rsp_want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, rsp_want.status, rsp.status);
            failed = 1'b1;
          end
        end
      end
      if (rsp_stall > 0) begin
        rsp_ready <= 1'b0;
        rsp_stall <= rsp_stall - 1;
      end else begin
        rsp_ready <= 1'b1;
        if (idling_on && $urandom_range(0, 7) == 0) rsp_stall <= $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    logic [CLU_W-1:0] heads_now[$];
    for (int i = 0; i < TABLE_ENTRIES; i++)
      shadow_links[i] = (i < RSV_ENTRIES) ? END_OF_CHAIN : '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // short chain built, walked, broken in the middle and freed
    push_req(CMD_ALLOC, 10'd0);
    push_req(CMD_ALLOC, 10'd1023);
    push_req(CMD_APPEND, 10'd3);
    push_req(CMD_APPEND, 10'd3);
    push_req(CMD_FIND_TAIL, 10'd3);
    push_req(CMD_FIND_TAIL, 10'd4);
    push_req(CMD_FIND_TAIL, 10'd0);
    push_req(CMD_FIND_TAIL, 10'd10);
    push_req(CMD_FREE_ONE, 10'd5);
    push_req(CMD_FIND_TAIL, 10'd3);
    push_req(CMD_APPEND, 10'd3);
    push_req(CMD_FREE_CHAIN, 10'd3);
    push_req(CMD_FREE_CHAIN, 10'd4);
    push_req(CMD_FREE_ONE, 10'd1023);
    // reserved entry freed and handed out again
    push_req(CMD_FREE_ONE, 10'd0);
    push_req(CMD_ALLOC, 10'd0);
    push_req(CMD_SPARE_LO, 10'd1023);
    push_req(CMD_SPARE_LO + CMD_W'(1), 10'd0);
    push_req(CMD_SPARE_HI, 10'd512);
    push_req(CMD_FIND_TAIL, 10'd1023);
    push_req(CMD_FREE_CHAIN, 10'd6);
    push_req(CMD_FREE_CHAIN, 10'd1023);
    push_req(CMD_APPEND, 10'd1023);
    push_req(CMD_APPEND, 10'd0);
    push_req(CMD_FIND_TAIL, 10'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      wait_room();
      pending_reqs.push_back(random_request());
    end

    // long chains grown back to back, no idling from here on
    idling_on = 1'b0;
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      wait_room();
      pending_reqs.push_back(fill_request());
    end
    while (pending_reqs.size() > 0 || req_valid) @(negedge clk);
    heads_now = chain_heads;
    while (heads_now.size() > FREE_HEADS) void'(heads_now.pop_front());
    foreach (heads_now[i]) begin
      wait_room();
      push_req(CMD_FREE_CHAIN, heads_now[i]);
    end
    push_req(CMD_ALLOC, 10'd0);
    push_req(CMD_ALLOC, 10'd0);
    push_req(CMD_APPEND, 10'd2);

    while (pending_reqs.size() > 0 || req_valid) @(posedge clk);
    while (expected_rsps.size() > 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 20) @(posedge clk);
    if (!failed && expected_rsps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/fccm_pkg.sv
hdl/fccm_dpath.sv
hdl/fccm_ctrl.sv
hdl/fat_cluster_chain_manager.sv
tb/sv/tb_fat_cluster_chain_manager.sv
